[design/itp_pkg.sv]
package itp_pkg;

    localparam int STACK_DEPTH_DEF = 16;

    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_OVERFLOW = 2'd1,
        ERR_CLOSE    = 2'd2,
        ERR_OPEN     = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        KIND_END,
        KIND_CLOSE,
        KIND_OP
    } kind_t;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic       clear;
        logic [7:0] data;
    } stk_ctrl_t;

    function automatic logic is_high(input logic [7:0] c);
        return (c == CH_MUL) || (c == CH_DIV);
    endfunction

endpackage

[design/itp_stack.sv]
module itp_stack
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    localparam int CNT_W = $clog2(STACK_DEPTH + 1),
    localparam int ADDR_W = $clog2(STACK_DEPTH)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  stk_ctrl_t        ctrl,
    output logic [CNT_W-1:0] count,
    output logic             open_any,
    output logic [7:0]       top
);

    logic [7:0]       mem [STACK_DEPTH];
    logic [7:0]       top_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] open_reg;
    logic [CNT_W-1:0] open_next;
    logic [CNT_W-1:0] count_dec;

    assign count_dec = count_reg - CNT_W'(1);

    always_comb
    begin
        count_next = count_reg;
        open_next  = open_reg;
        if (ctrl.clear)
        begin
            count_next = '0;
            open_next  = '0;
        end
        else if (ctrl.push)
        begin
            count_next = count_reg + CNT_W'(1);
            if (ctrl.data == CH_OPEN)
            begin
                open_next = open_reg + CNT_W'(1);
            end
        end
        else if (ctrl.pop)
        begin
            count_next = count_dec;
            if (top_reg == CH_OPEN)
            begin
                open_next = open_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            open_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            open_reg  <= open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[count_reg[ADDR_W-1:0]] <= ctrl.data;
        end
        top_reg <= mem[count_dec[ADDR_W-1:0]];
    end

    assign count    = count_reg;
    assign open_any = (open_reg != '0);
    assign top      = top_reg;

endmodule

[design/infix_to_postfix_converter.sv]
// Shunting-yard infix to postfix converter. One ASCII character (or an end
// mark) is taken per item; digits come out at once, operators wait on a stack
// of STACK_DEPTH entries and leave in postfix order, and the final result of
// each item carries last. Whitespace, '(' that does not overflow the stack and
// an operator or end mark that meets an empty stack give no result; a digit or
// an error found at the accepting edge goes straight to the output handshake.
// Any other operator, a matched ')' or an end mark with operators stacked
// passes through ST_FETCH, to read the new top of stack through the registered
// memory read port, and ST_DECIDE, to compare its rank, once for every popped
// operator and once more for the entry that ends the run. in_ready is low from
// the accepting edge until the item is finished, including the handshake of
// its last result.
module infix_to_postfix_converter
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] symbol,
    input  logic       end_of_expression,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_symbol,
    output logic       last,
    output logic [1:0] error
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    state_t           state_reg, state_next;
    kind_t            kind_reg, kind_next;
    logic [7:0]       c_reg, c_next;
    logic [7:0]       pend_reg, pend_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             done_reg, done_next;
    logic [7:0]       osym_reg, osym_next;
    logic             olast_reg, olast_next;
    err_t             oerr_reg, oerr_next;

    stk_ctrl_t        stk;
    logic [CNT_W-1:0] count;
    logic             open_any;
    logic [7:0]       top;
    logic             full;
    logic             empty;
    logic             is_digit;
    logic             is_space;
    logic             do_pop;

    itp_stack #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (stk),
        .count   (count),
        .open_any(open_any),
        .top     (top)
    );

    assign full     = (count == CNT_W'(STACK_DEPTH));
    assign empty    = (count == '0);
    assign is_digit = (symbol >= CH_ZERO) && (symbol <= CH_NINE);
    assign is_space = (symbol == CH_SPACE) || ((symbol >= CH_TAB) && (symbol <= CH_CR));

    always_comb
    begin
        case (kind_reg)
            KIND_END:   do_pop = !empty;
            KIND_CLOSE: do_pop = (top != CH_OPEN);
            KIND_OP:    do_pop = !empty && (top != CH_OPEN)
                                 && !(is_high(c_reg) && !is_high(top));
            default:    do_pop = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        c_next          = c_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        done_next       = done_reg;
        osym_next       = osym_reg;
        olast_next      = olast_reg;
        oerr_next       = oerr_reg;
        stk             = '0;
        in_ready        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready        = 1'b1;
                pend_valid_next = 1'b0;
                if (in_valid)
                begin
                    if (end_of_expression)
                    begin
                        if (open_any)
                        begin
                            stk.clear  = 1'b1;
                            osym_next  = '0;
                            olast_next = 1'b1;
                            oerr_next  = ERR_OPEN;
                            done_next  = 1'b1;
                            state_next = ST_EMIT;
                        end
                        else if (!empty)
                        begin
                            kind_next  = KIND_END;
                            state_next = ST_FETCH;
                        end
                    end
                    else if (is_digit)
                    begin
                        osym_next  = symbol;
                        olast_next = 1'b1;
                        oerr_next  = ERR_NONE;
                        done_next  = 1'b1;
                        state_next = ST_EMIT;
                    end
                    else if (is_space)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (symbol == CH_OPEN)
                    begin
                        if (full)
                        begin
                            stk.clear  = 1'b1;
                            osym_next  = '0;
                            olast_next = 1'b1;
                            oerr_next  = ERR_OVERFLOW;
                            done_next  = 1'b1;
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            stk.push = 1'b1;
                            stk.data = symbol;
                        end
                    end
                    else if (symbol == CH_CLOSE)
                    begin
                        if (!open_any)
                        begin
                            stk.clear  = 1'b1;
                            osym_next  = '0;
                            olast_next = 1'b1;
                            oerr_next  = ERR_CLOSE;
                            done_next  = 1'b1;
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            kind_next  = KIND_CLOSE;
                            state_next = ST_FETCH;
                        end
                    end
                    else if (empty)
                    begin
                        stk.push = 1'b1;
                        stk.data = symbol;
                    end
                    else
                    begin
                        kind_next  = KIND_OP;
                        c_next     = symbol;
                        state_next = ST_FETCH;
                    end
                end
            end

            ST_FETCH:
            begin
                state_next = ST_DECIDE;
            end

            ST_DECIDE:
            begin
                if (do_pop)
                begin
                    stk.pop         = 1'b1;
                    pend_next       = top;
                    pend_valid_next = 1'b1;
                    if (pend_valid_reg)
                    begin
                        osym_next  = pend_reg;
                        olast_next = 1'b0;
                        oerr_next  = ERR_NONE;
                        done_next  = 1'b0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
                else
                begin
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                    if (pend_valid_reg)
                    begin
                        osym_next  = pend_reg;
                        olast_next = 1'b1;
                        oerr_next  = ERR_NONE;
                        done_next  = 1'b1;
                        state_next = ST_EMIT;
                    end
                    case (kind_reg)
                        KIND_CLOSE:
                        begin
                            stk.pop = 1'b1;
                        end
                        KIND_OP:
                        begin
                            if (pend_valid_reg || !full)
                            begin
                                stk.push = 1'b1;
                                stk.data = c_reg;
                            end
                            else
                            begin
                                stk.clear  = 1'b1;
                                osym_next  = '0;
                                olast_next = 1'b1;
                                oerr_next  = ERR_OVERFLOW;
                                done_next  = 1'b1;
                                state_next = ST_EMIT;
                            end
                        end
                        default:
                        begin
                            stk.pop = 1'b0;
                        end
                    endcase
                end
            end

            ST_EMIT:
            begin
                if (out_ready)
                begin
                    state_next = done_reg ? ST_IDLE : ST_FETCH;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        c_reg     <= c_next;
        pend_reg  <= pend_next;
        osym_reg  <= osym_next;
        olast_reg <= olast_next;
        oerr_reg  <= oerr_next;
    end

    assign out_valid  = (state_reg == ST_EMIT);
    assign out_symbol = osym_reg;
    assign last       = olast_reg;
    assign error      = oerr_reg;

endmodule

[design/itp_checker.sv]
module itp_checker
    import itp_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] symbol,
    input logic       end_of_expression,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_symbol,
    input logic       last,
    input logic [1:0] error
);

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result is pending");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(symbol)
            && $stable(end_of_expression))
        else $error("input item changed while waiting");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_symbol)
            && $stable(last) && $stable(error))
        else $error("result changed while stalled");

    a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (error != ERR_NONE) |-> last && (out_symbol == 8'h00))
        else $error("error result not final or not zero");

    a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> !in_ready)
        else $error("input taken before the item's last result");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .symbol           (symbol),
    .end_of_expression(end_of_expression),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_symbol       (out_symbol),
    .last             (last),
    .error            (error)
);
